>>> src/csq_pkg.sv
// Shared types and codes for the counting semaphore table.
`timescale 1ns / 1ps

package csq_pkg;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_WAIT   = 2'd1;
    localparam logic [1:0] MODE_POST   = 2'd2;
    localparam logic [1:0] MODE_DELETE = 2'd3;

    localparam logic [3:0] STAT_CREATED  = 4'd0;
    localparam logic [3:0] STAT_EXISTS   = 4'd1;
    localparam logic [3:0] STAT_NO_SUCH  = 4'd2;
    localparam logic [3:0] STAT_ACQUIRED = 4'd3;
    localparam logic [3:0] STAT_BLOCKED  = 4'd4;
    localparam logic [3:0] STAT_QFULL    = 4'd5;
    localparam logic [3:0] STAT_INCR     = 4'd6;
    localparam logic [3:0] STAT_WOKE     = 4'd7;
    localparam logic [3:0] STAT_DELETED  = 4'd8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  sem_id;
        logic [7:0]  caller_pid;
        logic [31:0] initial_count;
    } request_t;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] woken_pid;
        logic       count_saturated;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

endpackage

>>> src/counting_semaphore_wait_queue.sv
// Counting semaphore table with per-entry FIFO of waiting pids.
//
//   channel   signals                  handshake
//   request   start, request, busy     taken when start && !busy
//   result    done, result             shown for a single cycle, no backpressure
//
// Create, wait and a post without waiters read the entry memory on the accept
// edge and write it back in the following cycle.
// A post that wakes a waiter adds one waiter memory read; its result leaves from drain.
// A delete with N waiters returns N woken results, one waiter memory read a cycle.
// Reset clears the valid bits and the sequencer; no clearing pass is needed.
// The receiver cannot stall: each result shows for one cycle with done high.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int NUM_SEMS    = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    localparam int SEM_W    = $clog2(NUM_SEMS);
    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int WT_DEPTH = NUM_SEMS * (2 ** PTR_W);

    typedef struct packed {
        logic [31:0]       count;
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [FILL_W-1:0] fill;
    } entry_t;

    function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    entry_t            ent_mem [NUM_SEMS];
    logic [7:0]        wt_mem  [WT_DEPTH];

    state_t            state_reg, state_next;
    request_t          req_reg;
    entry_t            ent_rd_reg;
    logic [7:0]        wt_rd_reg;
    logic [NUM_SEMS-1:0] valid_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] left_reg, left_next;
    result_t           res_reg, res_next;
    logic              done_reg, done_next;

    logic              accept;
    logic [SEM_W-1:0]  idx_in;
    logic [SEM_W-1:0]  idx_reg;
    logic              in_range;
    logic              present;

    logic              ent_we;
    entry_t            ent_wdata;
    logic              wt_we;
    logic              wt_re;
    logic [PTR_W-1:0]  wt_ptr;
    logic              valid_set;
    logic              valid_clr;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign idx_in   = SEM_W'(request.sem_id);
    assign idx_reg  = SEM_W'(req_reg.sem_id);
    assign in_range = (32'(req_reg.sem_id) < NUM_SEMS);
    assign present  = in_range && valid_reg[idx_reg];

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (valid_set)
                valid_reg[idx_reg] <= 1'b1;
            else if (valid_clr)
                valid_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= request;
        head_reg <= head_next;
        left_reg <= left_next;
        res_reg  <= res_next;
    end

    // Entry table: read on accept, write back during execute.
    always_ff @(posedge clk)
    begin
        if (accept)
            ent_rd_reg <= ent_mem[idx_in];
        if (ent_we)
            ent_mem[idx_reg] <= ent_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[{idx_reg, wt_ptr}] <= req_reg.caller_pid;
        if (wt_re)
            wt_rd_reg <= wt_mem[{idx_reg, wt_ptr}];
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        head_next  = head_reg;
        left_next  = left_reg;
        ent_we     = 1'b0;
        ent_wdata  = ent_rd_reg;
        wt_we      = 1'b0;
        wt_re      = 1'b0;
        wt_ptr     = ent_rd_reg.head;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                res_next   = '{status: STAT_NO_SUCH, woken_pid: 8'd0,
                               count_saturated: 1'b0, last: 1'b1};
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (req_reg.mode)
                    MODE_CREATE:
                    begin
                        if (!in_range)
                            res_next.status = STAT_NO_SUCH;
                        else if (present)
                            res_next.status = STAT_EXISTS;
                        else
                        begin
                            res_next.status = STAT_CREATED;
                            ent_we          = 1'b1;
                            ent_wdata       = '{count: req_reg.initial_count,
                                                head: '0, tail: '0, fill: '0};
                            valid_set       = 1'b1;
                        end
                    end

                    MODE_WAIT:
                    begin
                        if (!present)
                            res_next.status = STAT_NO_SUCH;
                        else if (ent_rd_reg.count != 32'd0)
                        begin
                            res_next.status = STAT_ACQUIRED;
                            ent_we          = 1'b1;
                            ent_wdata.count = ent_rd_reg.count - 32'd1;
                        end
                        else if (ent_rd_reg.fill >= FILL_W'(QUEUE_DEPTH))
                            res_next.status = STAT_QFULL;
                        else
                        begin
                            // enqueue caller at the tail
                            res_next.status = STAT_BLOCKED;
                            wt_we           = 1'b1;
                            wt_ptr          = ent_rd_reg.tail;
                            ent_we          = 1'b1;
                            ent_wdata.tail  = adv_ptr(ent_rd_reg.tail);
                            ent_wdata.fill  = ent_rd_reg.fill + FILL_W'(1);
                        end
                    end

                    MODE_POST:
                    begin
                        if (!present)
                            res_next.status = STAT_NO_SUCH;
                        else if (ent_rd_reg.fill != '0)
                        begin
                            // pop the oldest waiter; result leaves from drain
                            wt_re          = 1'b1;
                            ent_we         = 1'b1;
                            ent_wdata.head = adv_ptr(ent_rd_reg.head);
                            ent_wdata.fill = ent_rd_reg.fill - FILL_W'(1);
                            head_next      = adv_ptr(ent_rd_reg.head);
                            left_next      = FILL_W'(1);
                            done_next      = 1'b0;
                            state_next     = S_DRAIN;
                        end
                        else if (ent_rd_reg.count == 32'hFFFF_FFFF)
                        begin
                            res_next.status          = STAT_INCR;
                            res_next.count_saturated = 1'b1;
                        end
                        else
                        begin
                            res_next.status = STAT_INCR;
                            ent_we          = 1'b1;
                            ent_wdata.count = ent_rd_reg.count + 32'd1;
                        end
                    end

                    MODE_DELETE:
                    begin
                        if (!present)
                            res_next.status = STAT_NO_SUCH;
                        else
                        begin
                            valid_clr = 1'b1;
                            if (ent_rd_reg.fill == '0)
                                res_next.status = STAT_DELETED;
                            else
                            begin
                                wt_re      = 1'b1;
                                head_next  = adv_ptr(ent_rd_reg.head);
                                left_next  = ent_rd_reg.fill;
                                done_next  = 1'b0;
                                state_next = S_DRAIN;
                            end
                        end
                    end

                    default:
                    begin
                        res_next.status = STAT_NO_SUCH;
                    end
                endcase
            end

            S_DRAIN:
            begin
                // emit the pid read last cycle, fetch the next one
                res_next  = '{status: STAT_WOKE, woken_pid: wt_rd_reg,
                              count_saturated: 1'b0,
                              last: (left_reg == FILL_W'(1))};
                done_next = 1'b1;
                wt_re     = 1'b1;
                wt_ptr    = head_reg;
                head_next = adv_ptr(head_reg);
                left_next = left_reg - FILL_W'(1);
                if (left_reg == FILL_W'(1))
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !res_reg.last |-> busy)
        else $error("non-final result while sequencer is idle");

    a_single_only_woke: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.status != STAT_WOKE |-> res_reg.last)
        else $error("non-woke result not marked last");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == S_EXEC)
        else $error("accepted request did not enter execute");

    a_sat_incr: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.count_saturated |-> res_reg.status == STAT_INCR)
        else $error("saturation flag on a non-post result");

    a_drain_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> left_reg != '0)
        else $error("drain with no waiters left");

endmodule
